/* sv/path_cache_admit_and_lookup_defines.svh */
// Assertion macros for the path cache checker
`ifndef PATH_CACHE_ADMIT_AND_LOOKUP_DEFINES_SVH
`define PATH_CACHE_ADMIT_AND_LOOKUP_DEFINES_SVH

// Implication in the same cycle, sampled on clk, off during reset
`define PCAL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication into the next cycle
`define PCAL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/pcal_pkg.sv */
// Shared constants, codes and state type of the path cache
package pcal_pkg;

	localparam int MAX_PATHS    = 64;
	localparam int MAX_PATH_LEN = 64;
	localparam int MAX_DISTINCT = 4096;
	localparam int NODE_COST    = 32;
	localparam int ENTRY_COST   = 1;

	localparam int ID_W       = 24;
	localparam int PATH_IDX_W = $clog2(MAX_PATHS);
	localparam int ENT_IDX_W  = $clog2(MAX_PATH_LEN);
	localparam int SET_IDX_W  = $clog2(MAX_DISTINCT);
	localparam int CNT_W      = 7;
	localparam int LEN_W      = $clog2(MAX_PATH_LEN + 1);
	localparam int NSC_W      = $clog2(MAX_DISTINCT + 1);
	localparam int TALLY_W    = 13;
	localparam int TALLY_MAX  = 8191;
	localparam int USED_W     = 32;
	localparam int COST_W     = 34;

	localparam logic KIND_NODE  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic MODE_LIST  = 1'b0;
	localparam logic MODE_GRAPH = 1'b1;

	localparam logic CFG_MODE   = 1'b0;
	localparam logic CFG_BUDGET = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLOSE,
		ST_G_ENT_RD,
		ST_G_ENT,
		ST_G_SET_RD,
		ST_G_SET,
		ST_G_DONE,
		ST_Q_LEN_RD,
		ST_Q_LEN,
		ST_Q_ENT_RD,
		ST_Q_ENT,
		ST_FIN
	} state_t;

endpackage

/* sv/path_cache_admit_and_lookup.sv */
// Path cache: admits streamed paths under a bit budget and answers pair lookups
//
// Input channel (in_valid/in_stall): one beat is a path node (kind 0) or a query
// (kind 1). A path node without path_last gives no result and does not stall the input.
// The beat with path_last closes the path and gives one result; a query gives one.
// Output channel (out_valid/out_stall): one result beat, held in an output
// register while out_stall is high; the next input beat may be taken meanwhile.
// Steps, through registered reads of the path, length and node-set memories:
//   list-mode or rejected close: the close state, then the finish state loads the output register;
//   graph-mode close: each path node is read and compared with the set entries in
//     turn; a node absent from the set is charged and kept while the set has room;
//   query: each stored path's length and entries are read; a hit ends the scan.
// in_stall is high from the cycle after a beat that starts work until its result is
// loaded into the output register. Reset clears all counters, the charge and the
// node-set fill count; the node set is tracked by its fill count, so no clearing
// pass runs. Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready; the user must write it only while idle; the block does not enforce it.
module path_cache_admit_and_lookup (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [23:0] node_id,
	input  logic        path_last,
	input  logic [23:0] first_node,
	input  logic [23:0] second_node,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_query_result,
	output logic        hit,
	output logic        accepted,
	output logic [31:0] used_bits,
	output logic [6:0]  stored_paths,
	output logic [12:0] distinct_nodes
);

	localparam int ST_AW = pcal_pkg::PATH_IDX_W + pcal_pkg::ENT_IDX_W;

	pcal_pkg::state_t state_q, state_n;

	logic                        mode_q;
	logic [pcal_pkg::USED_W-1:0] budget_q;
	logic [pcal_pkg::CNT_W-1:0]  count_q;
	logic [pcal_pkg::LEN_W-1:0]  pend_q;
	logic                        ovf_q;
	logic [pcal_pkg::USED_W-1:0] used_q;
	logic [pcal_pkg::NSC_W-1:0]  nsc_q;
	logic [pcal_pkg::TALLY_W-1:0] tally_q;
	logic [pcal_pkg::CNT_W-1:0]  p_q;
	logic [pcal_pkg::LEN_W-1:0]  i_q;
	logic [pcal_pkg::NSC_W-1:0]  j_q;
	logic                        fa_q, fb_q;
	logic                        res_query_q, res_hit_q, res_acc_q;
	logic                        out_valid_q;

	logic [pcal_pkg::LEN_W-1:0]  len_q;
	logic [pcal_pkg::ID_W-1:0]   id_q, a_q, b_q;

	logic [pcal_pkg::ID_W-1:0]   store_mem [pcal_pkg::MAX_PATHS * pcal_pkg::MAX_PATH_LEN];
	logic [pcal_pkg::LEN_W-1:0]  len_mem   [pcal_pkg::MAX_PATHS];
	logic [pcal_pkg::ID_W-1:0]   set_mem   [pcal_pkg::MAX_DISTINCT];
	logic [pcal_pkg::ID_W-1:0]   st_rdata, set_rdata;
	logic [pcal_pkg::LEN_W-1:0]  len_rdata;

	logic                        in_acc, st_we, len_we, set_we;
	logic [ST_AW-1:0]            st_waddr, st_raddr;
	logic                        close_bad, admit, set_end, last_ent, q_a, q_b;
	logic [pcal_pkg::COST_W-1:0] entry_charge, node_charge, cost;
	logic [pcal_pkg::TALLY_W:0]  tally_sum;

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && !in_stall;

	assign close_bad    = ovf_q || (count_q >= pcal_pkg::CNT_W'(pcal_pkg::MAX_PATHS));
	assign entry_charge = (pcal_pkg::COST_W'(count_q) + pcal_pkg::COST_W'(1))
		* pcal_pkg::COST_W'(2 * pcal_pkg::ENTRY_COST);
	assign node_charge  = pcal_pkg::COST_W'(pend_q) * pcal_pkg::COST_W'(pcal_pkg::NODE_COST);
	assign cost = pcal_pkg::COST_W'(used_q) + node_charge
		+ ((mode_q == pcal_pkg::MODE_GRAPH) ? entry_charge : '0);
	assign admit     = !close_bad && (cost < pcal_pkg::COST_W'(budget_q));
	assign tally_sum = (pcal_pkg::TALLY_W + 1)'(tally_q) + (pcal_pkg::TALLY_W + 1)'(pend_q);
	assign set_end   = (j_q == nsc_q);
	assign last_ent  = (pcal_pkg::LEN_W'(i_q + 1'b1) == len_q);
	assign q_a       = fa_q || (st_rdata == a_q);
	assign q_b       = fb_q || (st_rdata == b_q);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			pcal_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (kind == pcal_pkg::KIND_QUERY) state_n = pcal_pkg::ST_Q_LEN_RD;
					else if (path_last) state_n = pcal_pkg::ST_CLOSE;
				end
			end
			pcal_pkg::ST_CLOSE: begin
				if (!admit || mode_q == pcal_pkg::MODE_LIST) state_n = pcal_pkg::ST_FIN;
				else if (pend_q == '0) state_n = pcal_pkg::ST_G_DONE;
				else state_n = pcal_pkg::ST_G_ENT_RD;
			end
			pcal_pkg::ST_G_ENT_RD: state_n = pcal_pkg::ST_G_ENT;
			pcal_pkg::ST_G_ENT:    state_n = pcal_pkg::ST_G_SET_RD;
			pcal_pkg::ST_G_SET_RD: begin
				if (!set_end) state_n = pcal_pkg::ST_G_SET;
				else if (last_ent) state_n = pcal_pkg::ST_G_DONE;
				else state_n = pcal_pkg::ST_G_ENT_RD;
			end
			pcal_pkg::ST_G_SET: begin
				if (set_rdata != id_q) state_n = pcal_pkg::ST_G_SET_RD;
				else if (last_ent) state_n = pcal_pkg::ST_G_DONE;
				else state_n = pcal_pkg::ST_G_ENT_RD;
			end
			pcal_pkg::ST_G_DONE: state_n = pcal_pkg::ST_FIN;
			pcal_pkg::ST_Q_LEN_RD: begin
				if (p_q == count_q) state_n = pcal_pkg::ST_FIN;
				else state_n = pcal_pkg::ST_Q_LEN;
			end
			pcal_pkg::ST_Q_LEN: state_n = pcal_pkg::ST_Q_ENT_RD;
			pcal_pkg::ST_Q_ENT_RD: begin
				if (i_q == len_q) state_n = pcal_pkg::ST_Q_LEN_RD;
				else state_n = pcal_pkg::ST_Q_ENT;
			end
			pcal_pkg::ST_Q_ENT: begin
				if (q_a && q_b) state_n = pcal_pkg::ST_FIN;
				else state_n = pcal_pkg::ST_Q_ENT_RD;
			end
			pcal_pkg::ST_FIN: begin
				if (!out_valid_q || !out_stall) state_n = pcal_pkg::ST_IDLE;
			end
			default: state_n = pcal_pkg::ST_IDLE;
		endcase
	end

	// memory controls and handshake
	always_comb begin
		in_stall = (state_q != pcal_pkg::ST_IDLE);
		st_we    = in_acc && (kind == pcal_pkg::KIND_NODE)
			&& (pend_q < pcal_pkg::LEN_W'(pcal_pkg::MAX_PATH_LEN))
			&& (count_q < pcal_pkg::CNT_W'(pcal_pkg::MAX_PATHS));
		st_waddr = {count_q[pcal_pkg::PATH_IDX_W-1:0], pend_q[pcal_pkg::ENT_IDX_W-1:0]};
		if (state_q == pcal_pkg::ST_Q_ENT_RD)
			st_raddr = {p_q[pcal_pkg::PATH_IDX_W-1:0], i_q[pcal_pkg::ENT_IDX_W-1:0]};
		else
			st_raddr = {count_q[pcal_pkg::PATH_IDX_W-1:0], i_q[pcal_pkg::ENT_IDX_W-1:0]};
		len_we = (state_q == pcal_pkg::ST_CLOSE) && admit;
		set_we = (state_q == pcal_pkg::ST_G_SET_RD) && set_end
			&& (nsc_q < pcal_pkg::NSC_W'(pcal_pkg::MAX_DISTINCT));
	end

	always_ff @(posedge clk) begin
		if (st_we) store_mem[st_waddr] <= node_id;
		st_rdata <= store_mem[st_raddr];
	end

	always_ff @(posedge clk) begin
		if (len_we) len_mem[count_q[pcal_pkg::PATH_IDX_W-1:0]] <= pend_q;
		len_rdata <= len_mem[p_q[pcal_pkg::PATH_IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (set_we) set_mem[nsc_q[pcal_pkg::SET_IDX_W-1:0]] <= id_q;
		set_rdata <= set_mem[j_q[pcal_pkg::SET_IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pcal_pkg::ST_IDLE;
			mode_q      <= pcal_pkg::MODE_LIST;
			budget_q    <= '0;
			count_q     <= '0;
			pend_q      <= '0;
			ovf_q       <= 1'b0;
			used_q      <= '0;
			nsc_q       <= '0;
			tally_q     <= '0;
			p_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			fa_q        <= 1'b0;
			fb_q        <= 1'b0;
			res_query_q <= 1'b0;
			res_hit_q   <= 1'b0;
			res_acc_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					pcal_pkg::CFG_MODE:   mode_q   <= cfg_data[0];
					pcal_pkg::CFG_BUDGET: budget_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == pcal_pkg::ST_FIN && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				pcal_pkg::ST_IDLE: begin
					if (in_acc && kind == pcal_pkg::KIND_QUERY) begin
						res_query_q <= 1'b1;
						res_hit_q   <= 1'b0;
						res_acc_q   <= 1'b0;
						p_q         <= '0;
					end else if (in_acc) begin
						// drop nodes past the path capacity and mark the overflow
						if (pend_q < pcal_pkg::LEN_W'(pcal_pkg::MAX_PATH_LEN))
							pend_q <= pend_q + 1'b1;
						else
							ovf_q <= 1'b1;
					end
				end
				pcal_pkg::ST_CLOSE: begin
					pend_q      <= '0;
					ovf_q       <= 1'b0;
					res_query_q <= 1'b0;
					res_hit_q   <= 1'b0;
					res_acc_q   <= admit;
					i_q         <= '0;
					if (admit && mode_q == pcal_pkg::MODE_LIST) begin
						used_q  <= used_q + node_charge[pcal_pkg::USED_W-1:0];
						count_q <= count_q + 1'b1;
						tally_q <= (tally_sum > (pcal_pkg::TALLY_W + 1)'(pcal_pkg::TALLY_MAX))
							? pcal_pkg::TALLY_W'(pcal_pkg::TALLY_MAX)
							: tally_sum[pcal_pkg::TALLY_W-1:0];
					end else if (admit) begin
						used_q <= used_q + entry_charge[pcal_pkg::USED_W-1:0];
					end
				end
				pcal_pkg::ST_G_ENT: j_q <= '0;
				pcal_pkg::ST_G_SET_RD: begin
					if (set_end) begin
						// absent node: charge it, keep it while the set has room
						used_q <= used_q + pcal_pkg::USED_W'(pcal_pkg::NODE_COST);
						if (set_we) nsc_q <= nsc_q + 1'b1;
						i_q <= i_q + 1'b1;
					end
				end
				pcal_pkg::ST_G_SET: begin
					if (set_rdata == id_q) i_q <= i_q + 1'b1;
					else j_q <= j_q + 1'b1;
				end
				pcal_pkg::ST_G_DONE: begin
					count_q <= count_q + 1'b1;
					tally_q <= (nsc_q > pcal_pkg::NSC_W'(pcal_pkg::TALLY_MAX))
						? pcal_pkg::TALLY_W'(pcal_pkg::TALLY_MAX)
						: pcal_pkg::TALLY_W'(nsc_q);
				end
				pcal_pkg::ST_Q_LEN: begin
					i_q  <= '0;
					fa_q <= 1'b0;
					fb_q <= 1'b0;
				end
				pcal_pkg::ST_Q_ENT_RD: begin
					if (i_q == len_q) p_q <= p_q + 1'b1;
				end
				pcal_pkg::ST_Q_ENT: begin
					fa_q <= q_a;
					fb_q <= q_b;
					i_q  <= i_q + 1'b1;
					if (q_a && q_b) res_hit_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == pcal_pkg::ST_IDLE && in_acc) begin
			a_q <= first_node;
			b_q <= second_node;
		end
		if (state_q == pcal_pkg::ST_CLOSE) len_q <= pend_q;
		if (state_q == pcal_pkg::ST_Q_LEN) len_q <= len_rdata;
		if (state_q == pcal_pkg::ST_G_ENT) id_q <= st_rdata;
		if (state_q == pcal_pkg::ST_FIN && (!out_valid_q || !out_stall)) begin
			is_query_result <= res_query_q;
			hit             <= res_hit_q;
			accepted        <= res_acc_q;
			used_bits       <= used_q;
			stored_paths    <= count_q;
			distinct_nodes  <= tally_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* sv/pcal_checker.sv */
// Port-level checks on the path cache, bound to the top level
`include "path_cache_admit_and_lookup_defines.svh"

module pcal_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        cfg_index,
	input logic [31:0] cfg_data,
	input logic        in_valid,
	input logic        in_stall,
	input logic        kind,
	input logic [23:0] node_id,
	input logic        path_last,
	input logic [23:0] first_node,
	input logic [23:0] second_node,
	input logic        out_valid,
	input logic        out_stall,
	input logic        is_query_result,
	input logic        hit,
	input logic        accepted,
	input logic [31:0] used_bits,
	input logic [6:0]  stored_paths,
	input logic [12:0] distinct_nodes
);

	`PCAL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped while stalled")
	`PCAL_ASSERT_IMP(a_query_flags, out_valid && is_query_result == pcal_pkg::KIND_QUERY, !accepted, "query result marked accepted")
	`PCAL_ASSERT_IMP(a_insert_flags, out_valid && !is_query_result, !hit, "insertion result marked hit")
	`PCAL_ASSERT_IMP(a_paths_cap, out_valid, stored_paths <= 7'(pcal_pkg::MAX_PATHS), "stored path count above capacity")

endmodule

bind path_cache_admit_and_lookup pcal_checker u_pcal_checker (.*);
